>>> sv/dnsab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnsab_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_END   = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  // how a byte step is gated by the packet cap
  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_HI     = 2'd1,
    MODE_LO     = 2'd2
  } mode_t;

  // where a byte step takes its value from
  typedef enum logic [4:0] {
    SRC_CONST    = 5'd0,
    SRC_TID_HI   = 5'd1,
    SRC_TID_LO   = 5'd2,
    SRC_FLAGS_LO = 5'd3,
    SRC_FOUND    = 5'd4,
    SRC_TYPE_HI  = 5'd5,
    SRC_TYPE_LO  = 5'd6,
    SRC_CLASS_HI = 5'd7,
    SRC_CLASS_LO = 5'd8,
    SRC_TTL3     = 5'd9,
    SRC_TTL2     = 5'd10,
    SRC_TTL1     = 5'd11,
    SRC_TTL0     = 5'd12,
    SRC_ADDR3    = 5'd13,
    SRC_ADDR2    = 5'd14,
    SRC_ADDR1    = 5'd15,
    SRC_ADDR0    = 5'd16,
    SRC_LEN      = 5'd17,
    SRC_STORE    = 5'd18
  } src_t;

  typedef struct packed {
    src_t        src;
    mode_t       mode;
    logic [7:0]  cbyte;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic        accept;
    kind_t       kind;
    logic        step;
    mode_t       mode;
    src_t        src;
    logic [7:0]  cbyte;
    logic        clr_label;
    logic        finish;
    logic        fin_close;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic held_found;
    logic name_full;
    logic label_empty;
  } sts_t;

  localparam logic [7:0] DOT_CHAR      = 8'h2E;
  localparam logic [7:0] FLAGS_HI      = 8'h81;
  localparam logic [7:0] FLAGS_LO_HIT  = 8'h80;
  localparam logic [7:0] FLAGS_LO_MISS = 8'h83;
  localparam logic [7:0] PTR_HI        = 8'hC0;
  localparam logic [7:0] PTR_LO        = 8'h0C;
  localparam logic [7:0] RDLEN_LO      = 8'h04;
  localparam logic [31:0] TTL_RESET    = 32'd15;

  localparam int HDR_LAST        = 11;
  localparam int CLOSE_LAST_MISS = 4;
  localparam int CLOSE_LAST_HIT  = 20;

  // header: id, flags, qdcount 1, ancount, nscount 0, arcount 0
  function automatic entry_t header_entry(input logic [4:0] idx);
    entry_t e;
    e = '{src: SRC_CONST, mode: MODE_HI, cbyte: 8'h00};
    case (idx)
      5'd0:  e = '{src: SRC_TID_HI,   mode: MODE_HI, cbyte: 8'h00};
      5'd1:  e = '{src: SRC_TID_LO,   mode: MODE_LO, cbyte: 8'h00};
      5'd2:  e = '{src: SRC_CONST,    mode: MODE_HI, cbyte: FLAGS_HI};
      5'd3:  e = '{src: SRC_FLAGS_LO, mode: MODE_LO, cbyte: 8'h00};
      5'd4:  e = '{src: SRC_CONST,    mode: MODE_HI, cbyte: 8'h00};
      5'd5:  e = '{src: SRC_CONST,    mode: MODE_LO, cbyte: 8'h01};
      5'd6:  e = '{src: SRC_CONST,    mode: MODE_HI, cbyte: 8'h00};
      5'd7:  e = '{src: SRC_FOUND,    mode: MODE_LO, cbyte: 8'h00};
      5'd8:  e = '{src: SRC_CONST,    mode: MODE_HI, cbyte: 8'h00};
      5'd9:  e = '{src: SRC_CONST,    mode: MODE_LO, cbyte: 8'h00};
      5'd10: e = '{src: SRC_CONST,    mode: MODE_HI, cbyte: 8'h00};
      5'd11: e = '{src: SRC_CONST,    mode: MODE_LO, cbyte: 8'h00};
      default: e = '{src: SRC_CONST,  mode: MODE_HI, cbyte: 8'h00};
    endcase
    return e;
  endfunction

  // close: terminator, qtype, qclass, then the answer record
  function automatic entry_t close_entry(input logic [4:0] idx);
    entry_t e;
    e = '{src: SRC_CONST, mode: MODE_SINGLE, cbyte: 8'h00};
    case (idx)
      5'd0:  e = '{src: SRC_CONST,    mode: MODE_SINGLE, cbyte: 8'h00};
      5'd1:  e = '{src: SRC_TYPE_HI,  mode: MODE_HI,     cbyte: 8'h00};
      5'd2:  e = '{src: SRC_TYPE_LO,  mode: MODE_LO,     cbyte: 8'h00};
      5'd3:  e = '{src: SRC_CLASS_HI, mode: MODE_HI,     cbyte: 8'h00};
      5'd4:  e = '{src: SRC_CLASS_LO, mode: MODE_LO,     cbyte: 8'h00};
      5'd5:  e = '{src: SRC_CONST,    mode: MODE_HI,     cbyte: PTR_HI};
      5'd6:  e = '{src: SRC_CONST,    mode: MODE_LO,     cbyte: PTR_LO};
      5'd7:  e = '{src: SRC_TYPE_HI,  mode: MODE_HI,     cbyte: 8'h00};
      5'd8:  e = '{src: SRC_TYPE_LO,  mode: MODE_LO,     cbyte: 8'h00};
      5'd9:  e = '{src: SRC_CLASS_HI, mode: MODE_HI,     cbyte: 8'h00};
      5'd10: e = '{src: SRC_CLASS_LO, mode: MODE_LO,     cbyte: 8'h00};
      5'd11: e = '{src: SRC_TTL3,     mode: MODE_HI,     cbyte: 8'h00};
      5'd12: e = '{src: SRC_TTL2,     mode: MODE_LO,     cbyte: 8'h00};
      5'd13: e = '{src: SRC_TTL1,     mode: MODE_HI,     cbyte: 8'h00};
      5'd14: e = '{src: SRC_TTL0,     mode: MODE_LO,     cbyte: 8'h00};
      5'd15: e = '{src: SRC_CONST,    mode: MODE_HI,     cbyte: 8'h00};
      5'd16: e = '{src: SRC_CONST,    mode: MODE_LO,     cbyte: RDLEN_LO};
      5'd17: e = '{src: SRC_ADDR3,    mode: MODE_SINGLE, cbyte: 8'h00};
      5'd18: e = '{src: SRC_ADDR2,    mode: MODE_SINGLE, cbyte: 8'h00};
      5'd19: e = '{src: SRC_ADDR1,    mode: MODE_SINGLE, cbyte: 8'h00};
      5'd20: e = '{src: SRC_ADDR0,    mode: MODE_SINGLE, cbyte: 8'h00};
      default: e = '{src: SRC_CONST,  mode: MODE_SINGLE, cbyte: 8'h00};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

>>> sv/dnsab_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dnsab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/dnsab_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module dnsab_dpath
  import dnsab_pkg::*;
#(
  parameter int MAX_LABEL    = 63,
  parameter int MAX_NAME     = 255,
  parameter int PACKET_LIMIT = 512,
  localparam int LBL_W  = $clog2(MAX_LABEL + 1),
  localparam int AW     = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1,
  localparam int NAME_W = $clog2(MAX_NAME + 1),
  localparam int WP_W   = $clog2(PACKET_LIMIT + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  input  wire logic [AW-1:0]     rd_addr,
  output sts_t                   sts,
  output logic [LBL_W-1:0]       label_len,
  input  wire logic [7:0]        in_name_byte,
  input  wire logic [15:0]       in_transaction_id,
  input  wire logic [15:0]       in_query_type,
  input  wire logic [15:0]       in_query_class,
  input  wire logic              in_record_found,
  input  wire logic [31:0]       in_record_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_run_last,
  output logic                   out_packet_last,
  input  wire logic              cfg_wr_en,
  input  wire logic [31:0]       cfg_wr_data
);

  logic [WP_W-1:0]   wp_r, wp_nxt;
  logic [LBL_W-1:0]  lbl_len_r, lbl_len_nxt;
  logic [NAME_W-1:0] name_len_r, name_len_nxt;
  logic [15:0]       type_r, type_nxt;
  logic [15:0]       class_r, class_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       ttl_r, ttl_nxt;
  logic [15:0]       tid_r, tid_nxt;
  logic              hi_ok_r, hi_ok_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [7:0]        pend_byte_r, pend_byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              run_last_r, run_last_nxt;
  logic              pkt_last_r, pkt_last_nxt;

  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic              fits_single;
  logic              fits_pair;
  logic              emit;
  logic [7:0]        step_byte;
  logic              name_full;
  logic              lbl_room;

  dnsab_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lbl_len_r[AW-1:0]),
    .wdata (in_name_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign name_full   = (name_len_r == NAME_W'(MAX_NAME));
  assign lbl_room    = (lbl_len_r < LBL_W'(MAX_LABEL));
  assign fits_single = (wp_r < WP_W'(PACKET_LIMIT));
  assign fits_pair   = (({1'b0, wp_r} + (WP_W + 1)'(2)) <= (WP_W + 1)'(PACKET_LIMIT));

  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.held_found  = found_r;
  assign sts.name_full   = name_full;
  assign sts.label_empty = (lbl_len_r == '0);
  assign label_len       = lbl_len_r;

  always_comb begin
    case (cmd.mode)
      MODE_SINGLE: emit = fits_single;
      MODE_HI:     emit = fits_pair;
      MODE_LO:     emit = hi_ok_r;
      default:     emit = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_CONST:    step_byte = cmd.cbyte;
      SRC_TID_HI:   step_byte = tid_r[15:8];
      SRC_TID_LO:   step_byte = tid_r[7:0];
      SRC_FLAGS_LO: step_byte = found_r ? FLAGS_LO_HIT : FLAGS_LO_MISS;
      SRC_FOUND:    step_byte = {7'd0, found_r};
      SRC_TYPE_HI:  step_byte = type_r[15:8];
      SRC_TYPE_LO:  step_byte = type_r[7:0];
      SRC_CLASS_HI: step_byte = class_r[15:8];
      SRC_CLASS_LO: step_byte = class_r[7:0];
      SRC_TTL3:     step_byte = ttl_r[31:24];
      SRC_TTL2:     step_byte = ttl_r[23:16];
      SRC_TTL1:     step_byte = ttl_r[15:8];
      SRC_TTL0:     step_byte = ttl_r[7:0];
      SRC_ADDR3:    step_byte = addr_r[31:24];
      SRC_ADDR2:    step_byte = addr_r[23:16];
      SRC_ADDR1:    step_byte = addr_r[15:8];
      SRC_ADDR0:    step_byte = addr_r[7:0];
      SRC_LEN:      step_byte = 8'(lbl_len_r);
      SRC_STORE:    step_byte = ram_rdata;
      default:      step_byte = 8'h00;
    endcase
  end

  always_comb begin
    wp_nxt         = wp_r;
    lbl_len_nxt    = lbl_len_r;
    name_len_nxt   = name_len_r;
    type_nxt       = type_r;
    class_nxt      = class_r;
    found_nxt      = found_r;
    addr_nxt       = addr_r;
    ttl_nxt        = ttl_r;
    tid_nxt        = tid_r;
    hi_ok_nxt      = hi_ok_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    run_last_nxt   = run_last_r;
    pkt_last_nxt   = pkt_last_r;
    ram_we         = 1'b0;

    if (cfg_wr_en) begin
      ttl_nxt = cfg_wr_data;
    end

    if (cmd.accept) begin
      case (cmd.kind)
        KIND_START: begin
          wp_nxt       = '0;
          lbl_len_nxt  = '0;
          name_len_nxt = '0;
          type_nxt     = in_query_type;
          class_nxt    = in_query_class;
          found_nxt    = in_record_found;
          addr_nxt     = in_record_address;
          tid_nxt      = in_transaction_id;
        end
        KIND_NAME: begin
          if (!name_full) begin
            name_len_nxt = name_len_r + 1'b1;
            if (in_name_byte != DOT_CHAR && lbl_room) begin
              ram_we      = 1'b1;
              lbl_len_nxt = lbl_len_r + 1'b1;
            end
          end
        end
        KIND_CLOSE: lbl_len_nxt = '0;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.step) begin
      if (cmd.mode == MODE_HI) begin
        hi_ok_nxt = emit;
      end
      if (emit) begin
        wp_nxt = wp_r + 1'b1;
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_byte_r;
          run_last_nxt  = 1'b0;
          pkt_last_nxt  = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_byte_nxt  = step_byte;
      end
    end

    if (cmd.clr_label) begin
      lbl_len_nxt = '0;
    end

    // held byte goes out tagged as the item's last
    if (cmd.finish && pend_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = pend_byte_r;
      run_last_nxt   = 1'b1;
      pkt_last_nxt   = cmd.fin_close;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      lbl_len_r    <= '0;
      name_len_r   <= '0;
      type_r       <= '0;
      class_r      <= '0;
      found_r      <= 1'b0;
      addr_r       <= '0;
      ttl_r        <= TTL_RESET;
      hi_ok_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      wp_r         <= wp_nxt;
      lbl_len_r    <= lbl_len_nxt;
      name_len_r   <= name_len_nxt;
      type_r       <= type_nxt;
      class_r      <= class_nxt;
      found_r      <= found_nxt;
      addr_r       <= addr_nxt;
      ttl_r        <= ttl_nxt;
      hi_ok_r      <= hi_ok_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    tid_r       <= tid_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    run_last_r  <= run_last_nxt;
    pkt_last_r  <= pkt_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = run_last_r;
  assign out_packet_last = pkt_last_r;

endmodule

`default_nettype wire

>>> sv/dnsab_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dnsab_ctrl
  import dnsab_pkg::*;
#(
  parameter int MAX_LABEL = 63,
  localparam int LBL_W  = $clog2(MAX_LABEL + 1),
  localparam int AW     = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1,
  localparam int STEP_W = (LBL_W > 5) ? LBL_W : 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_kind,
  input  wire logic [7:0]       in_name_byte,
  input  wire sts_t             sts,
  input  wire logic [LBL_W-1:0] label_len,
  output cmd_t                  cmd,
  output logic [AW-1:0]         rd_addr
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_HEADER = 5'b00010,
    ST_FLUSH  = 5'b00100,
    ST_CLOSE  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [STEP_W-1:0]  step_m1;
  logic               fin_close_r, fin_close_nxt;
  kind_t              kind;
  entry_t             ent;
  logic               accept;
  logic               last;

  assign kind     = kind_t'(in_kind);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign step_m1  = step_r - 1'b1;

  // store data is registered behind the address, so hold the previous index on a stall
  assign rd_addr = cmd.step ? step_r[AW-1:0] : step_m1[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    fin_close_nxt = fin_close_r;
    cmd           = '0;
    ent           = '{src: SRC_CONST, mode: MODE_SINGLE, cbyte: 8'h00};
    last          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.accept    = 1'b1;
          cmd.kind      = kind;
          step_nxt      = '0;
          fin_close_nxt = (kind == KIND_CLOSE);
          case (kind)
            KIND_START: state_nxt = ST_HEADER;
            KIND_NAME: begin
              if (!sts.name_full && in_name_byte == DOT_CHAR && !sts.label_empty) begin
                state_nxt = ST_FLUSH;
              end
            end
            KIND_END: begin
              if (!sts.label_empty) begin
                state_nxt = ST_FLUSH;
              end
            end
            KIND_CLOSE: state_nxt = ST_CLOSE;
            default: ;
          endcase
        end
      end
      ST_HEADER: begin
        ent       = header_entry(step_r[4:0]);
        cmd.src   = ent.src;
        cmd.mode  = ent.mode;
        cmd.cbyte = ent.cbyte;
        last      = (step_r == STEP_W'(HDR_LAST));
      end
      ST_FLUSH: begin
        cmd.src  = (step_r == '0) ? SRC_LEN : SRC_STORE;
        cmd.mode = MODE_SINGLE;
        last     = (step_r == STEP_W'(label_len));
      end
      ST_CLOSE: begin
        ent       = close_entry(step_r[4:0]);
        cmd.src   = ent.src;
        cmd.mode  = ent.mode;
        cmd.cbyte = ent.cbyte;
        last      = sts.held_found ? (step_r == STEP_W'(CLOSE_LAST_HIT))
                                   : (step_r == STEP_W'(CLOSE_LAST_MISS));
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish    = 1'b1;
          cmd.fin_close = fin_close_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if ((state_r == ST_HEADER || state_r == ST_FLUSH || state_r == ST_CLOSE)
        && sts.out_free) begin
      cmd.step = 1'b1;
      if (last) begin
        cmd.clr_label = (state_r == ST_FLUSH);
        state_nxt     = ST_FINISH;
        step_nxt      = '0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      fin_close_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fin_close_r <= fin_close_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/dns_a_response_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// dns a-record response builder. a start beat (kind 0) emits the 12-byte header, name-byte
// beats (kind 1) collect the dotted query name into a label store, a dot that closes a
// non-empty label below the name cap sends it out as a length byte plus its bytes, an
// end-of-name beat (kind 2) sends the last label, and a close beat (kind 3) emits the root
// terminator, qtype, qclass and, when the record was found, the answer record (pointer to
// offset 12, type, class, ttl from cfg_wr_data, rdlength 4, address). every output beat
// carries one packet byte; run_last marks the last byte caused by an input beat and
// packet_last the last byte of a close. output stops at PACKET_LIMIT bytes, with 16-bit
// fields written whole or not at all. a beat that starts no byte sequence is only accepted;
// that is a name byte other than a dot ending a non-empty label below the name cap, or an
// end of name with no label pending. any other beat is accepted, runs one byte step per
// cycle while out_ready does not stall it (12 for the header, 1 plus the label length for
// a label, 5 or 21 for a close) whether or not the packet cap drops the byte, then releases
// the held last byte via the single byte-step sequencer. a result in the output register
// does not block the next input beat; back-pressure on out_ready stalls the sequencer.
// the ttl register resets to 15 and may only be written while the block is idle.

module dns_a_response_builder
  import dnsab_pkg::*;
#(
  parameter int MAX_LABEL    = 63,
  parameter int MAX_NAME     = 255,
  parameter int PACKET_LIMIT = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_name_byte,
  input  wire logic [15:0] in_transaction_id,
  input  wire logic [15:0] in_query_type,
  input  wire logic [15:0] in_query_class,
  input  wire logic        in_record_found,
  input  wire logic [31:0] in_record_address,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_packet_last,
  // ttl register
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  localparam int LBL_W = $clog2(MAX_LABEL + 1);
  localparam int AW    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [LBL_W-1:0] label_len;
  logic [AW-1:0]    rd_addr;

  // sequencer: walks header, label and close byte lists
  dnsab_ctrl #(
    .MAX_LABEL (MAX_LABEL)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_name_byte (in_name_byte),
    .sts          (sts),
    .label_len    (label_len),
    .cmd          (cmd),
    .rd_addr      (rd_addr)
  );

  // held fields, label store, packet cap and the output register
  dnsab_dpath #(
    .MAX_LABEL    (MAX_LABEL),
    .MAX_NAME     (MAX_NAME),
    .PACKET_LIMIT (PACKET_LIMIT)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .sts               (sts),
    .label_len         (label_len),
    .in_name_byte      (in_name_byte),
    .in_transaction_id (in_transaction_id),
    .in_query_type     (in_query_type),
    .in_query_class    (in_query_class),
    .in_record_found   (in_record_found),
    .in_record_address (in_record_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_packet_last   (out_packet_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

endmodule

`default_nettype wire
